// File: rtl/core/earliest_free_machine_scheduler_assert.svh
// Assertion macros for the earliest-free-machine scheduler
`ifndef EARLIEST_FREE_MACHINE_SCHEDULER_ASSERT_SVH
`define EARLIEST_FREE_MACHINE_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define EFMS_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("scheduler assertion failed");
`define EFMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");
`else
`define EFMS_ASSERT(lbl, expr)
`define EFMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/efms_pkg.sv
// Shared constants and types of the earliest-free-machine scheduler
package efms_pkg;

	localparam int MAX_MACHINES = 64;
	localparam int TIME_W       = 32;
	localparam int CNT_W        = $clog2(MAX_MACHINES + 1);
	localparam int CFG_W        = 7;

	typedef enum logic {
		OP_INSERT,
		OP_REPLACE
	} efms_op_t;

	typedef struct packed {
		logic              en;
		efms_op_t          op;
		logic [TIME_W-1:0] v;
	} efms_cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] val;
		logic              lt;
	} efms_link_t;

endpackage

// File: rtl/core/efms_cell.sv
// One cell of the sorted finish-time chain
module efms_cell (
	input  logic                clk,
	input  efms_pkg::efms_cmd_t cmd,
	input  logic                occ,
	input  logic                head,
	input  efms_pkg::efms_link_t left,
	input  efms_pkg::efms_link_t right,
	output efms_pkg::efms_link_t self
);

	logic [efms_pkg::TIME_W-1:0] val_q;
	logic                        lt;

	assign lt       = occ && (val_q < cmd.v);
	assign self.val = val_q;
	assign self.lt  = lt;

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			unique case (cmd.op)
				efms_pkg::OP_INSERT: begin
					// keep smaller values, drop v in at the boundary, shift larger right
					if (!lt) begin
						val_q <= left.lt ? cmd.v : left.val;
					end
				end
				efms_pkg::OP_REPLACE: begin
					// head leaves, smaller values shift left, v lands at the boundary
					if (right.lt) begin
						val_q <= right.val;
					end else if (lt || head) begin
						val_q <= cmd.v;
					end
				end
				default: val_q <= val_q;
			endcase
		end
	end

endmodule

// File: rtl/core/efms_chain.sv
// Row of cells holding busy finish times in ascending order
module efms_chain (
	input  logic                              clk,
	input  efms_pkg::efms_cmd_t               cmd,
	input  logic [efms_pkg::CNT_W-1:0]        busy,
	output logic [efms_pkg::TIME_W-1:0]       head_val
);

	efms_pkg::efms_link_t links [efms_pkg::MAX_MACHINES];
	efms_pkg::efms_link_t lbound;
	efms_pkg::efms_link_t rbound;

	assign lbound.val = '0;
	assign lbound.lt  = 1'b1;
	assign rbound.val = '0;
	assign rbound.lt  = 1'b0;

	for (genvar i = 0; i < efms_pkg::MAX_MACHINES; i++) begin : g_cell
		efms_cell u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.occ  (busy > efms_pkg::CNT_W'(i)),
			.head (i == 0),
			.left ((i == 0) ? lbound : links[(i == 0) ? 0 : i - 1]),
			.right((i == efms_pkg::MAX_MACHINES - 1) ? rbound :
				links[(i == efms_pkg::MAX_MACHINES - 1) ? i : i + 1]),
			.self (links[i])
		);
	end

	assign head_val = links[0].val;

endmodule

// File: rtl/core/earliest_free_machine_scheduler.sv
// Top level of the earliest-free-machine scheduler
// Usage:
//  s_* channel takes one task request: tdata = {duration, arrival_time}.
//  m_* channel returns one result per task: tdata = {makespan, finish_time},
//  tuser = saturated.
//  cfg_* channel writes machine_count; write only while no task is in flight.
// Pipeline:
//  A task accepted at one edge has its finish time computed from the chain
//  head and registered in the compute stage; once the output register is
//  free, the cell chain is updated and the result is loaded into the output
//  register, raising m_tvalid. No new task is taken while one is in the
//  compute stage, as the next task's head lookup needs the chain update.
// Stalls: a result waits in the output register; the next request is still
//  taken, and it holds in the compute stage until the output frees up.
// Reset: no busy machines, makespan zero, machine_count one.
module earliest_free_machine_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [2*efms_pkg::TIME_W-1:0]   s_tdata,   // arrival_time, duration
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [2*efms_pkg::TIME_W-1:0]   m_tdata,   // finish_time, makespan
	output logic                            m_tuser,   // saturated
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [efms_pkg::CFG_W-1:0]      cfg_data
);

`include "earliest_free_machine_scheduler_assert.svh"

	localparam int TW = efms_pkg::TIME_W;

	logic [efms_pkg::CFG_W-1:0] mcount_q;
	logic [efms_pkg::CNT_W-1:0] busy_q;
	logic [efms_pkg::CNT_W-1:0] eff_n;
	logic [TW-1:0]              latest_q;
	logic [TW-1:0]              head_val;
	logic [TW-1:0]              arrival;
	logic [TW-1:0]              dur;
	logic [TW-1:0]              start;
	logic [TW:0]                sum;
	logic                       ins;
	logic                       accept;
	logic                       fire;
	logic [TW-1:0]              new_latest;

	logic                       valid_s1;
	logic [TW-1:0]              v_s1;
	logic                       clip_s1;
	efms_pkg::efms_op_t         op_s1;

	efms_pkg::efms_cmd_t        cmd;

	assign cfg_ready = 1'b1;
	assign arrival   = s_tdata[TW-1:0];
	assign dur       = s_tdata[2*TW-1:TW];

	always_comb begin
		if (mcount_q == '0) begin
			eff_n = efms_pkg::CNT_W'(1);
		end else if (int'(mcount_q) > efms_pkg::MAX_MACHINES) begin
			eff_n = efms_pkg::CNT_W'(efms_pkg::MAX_MACHINES);
		end else begin
			eff_n = efms_pkg::CNT_W'(mcount_q);
		end
	end

	assign ins    = busy_q < eff_n;
	assign start  = (ins || head_val < arrival) ? arrival : head_val;
	assign sum    = {1'b0, start} + {1'b0, dur};
	assign s_tready = !valid_s1;
	assign accept = s_tvalid && s_tready;
	assign fire   = valid_s1 && (!m_tvalid || m_tready);

	assign cmd.en = fire;
	assign cmd.op = op_s1;
	assign cmd.v  = v_s1;

	assign new_latest = (v_s1 > latest_q) ? v_s1 : latest_q;

	efms_chain u_chain (
		.clk     (clk),
		.cmd     (cmd),
		.busy    (busy_q),
		.head_val(head_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcount_q <= efms_pkg::CFG_W'(1);
			busy_q   <= '0;
			latest_q <= '0;
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mcount_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				latest_q <= new_latest;
				m_tvalid <= 1'b1;
				if (op_s1 == efms_pkg::OP_INSERT) begin
					busy_q <= busy_q + efms_pkg::CNT_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1    <= sum[TW] ? '1 : sum[TW-1:0];
			clip_s1 <= sum[TW];
			op_s1   <= ins ? efms_pkg::OP_INSERT : efms_pkg::OP_REPLACE;
		end
		if (fire) begin
			m_tdata <= {new_latest, v_s1};
			m_tuser <= clip_s1;
		end
	end

	`EFMS_ASSERT(a_busy_bound, int'(busy_q) <= efms_pkg::MAX_MACHINES)
	`EFMS_ASSERT_NEXT(a_replace_keeps_busy, fire && op_s1 == efms_pkg::OP_REPLACE, $stable(busy_q))
	`EFMS_ASSERT(a_makespan_covers, !m_tvalid || m_tdata[2*TW-1:TW] >= m_tdata[TW-1:0])
	`EFMS_ASSERT(a_clip_is_max, !(m_tvalid && m_tuser) || (&m_tdata[TW-1:0]))

endmodule
